FILE: src/assert_macros.svh
// assertion helpers used by the top-level rtl file
// each macro expands to one labeled concurrent assertion on the rising clock edge
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle, ignored during reset
`define ASSERT_SAME(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed");

// condition implies consequence in the next cycle, ignored during reset
`define ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: src/bpt_pkg.sv
// shared types, constants and lookup tables for the byte plane tag text encoder
// no dependencies
`default_nettype none

package bpt_pkg;

   localparam int FIFO_DEPTH = 4;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_TAG  = 1'b1;

   localparam int TAG_ENTRIES = 81;
   localparam logic [6:0] TAG_LAST = 7'(TAG_ENTRIES - 1);

   // first character sits in the most significant byte
   localparam logic [8*256-1:0] DATA_STR =
      {"@ABCDEFGHIJKLMNOPQRSTUVWXYZ[2]^/",
       "_!*#$%$'()*+,-./0123456789:;(=)?",
       "@ABCDEFGHIJKLMNOPQRSTUVWXYZ[!]^_",
       "`abcdefghijklmnopqrstuvwxyz{|}~?",
       "`abcdefghijklmnopqrstuvwxyz{|}~.",
       "_!0#$%#'()*+,-./0123456789:;1=3?",
       "@ABCDEFGHIJKLMNOPQRSTUVWXYZ[4]^7",
       "`abcdefghijklmnopqrstuvwxyz{|}~="};

   localparam logic [8*TAG_ENTRIES-1:0] TAG_STR =
      {"`.^,JK|ST", "~@ELMNUVW", ":GHOPQXYZ",
       "'abijkrst", "cdelmnuvw", "fghopqxyz",
       ";129[]FI(", "345{}A)=#", "678BCD*$%"};

   typedef struct packed {
      logic       kind;
      logic [7:0] code;
      logic       last;
   } rsp_entry_type;

   typedef struct packed {
      rsp_entry_type data;
      rsp_entry_type tag;
      logic          close;
   } enc_out_type;

   function automatic logic [7:0] data_char(input logic [7:0] b);
      logic [10:0] base;
      base = {~b, 3'b000};
      return DATA_STR[base +: 8];
   endfunction

   function automatic logic [7:0] tag_char(input logic [6:0] idx);
      logic [6:0]  rev;
      logic [9:0]  base;
      rev  = TAG_LAST - idx;
      base = {rev, 3'b000};
      return TAG_STR[base +: 8];
   endfunction

   // plane 1 for control-like codes and a few punctuation marks, else 0 low half / 2 high half
   function automatic logic [1:0] byte_plane(input logic [7:0] b);
      logic [6:0] low;
      logic       special;
      low = b[6:0];
      special = (low == 7'd34) || (low == 7'd38) || (low == 7'd60) || (low == 7'd62)
             || (low == 7'd92) || (low == 7'd95) || (low == 7'd127);
      if (low < 7'd32 || special) begin
         return 2'd1;
      end
      return b[7] ? 2'd2 : 2'd0;
   endfunction

   function automatic logic [4:0] pos_weight(input logic [1:0] pos);
      logic [4:0] w;
      unique case (pos)
         2'd0: w = 5'd27;
         2'd1: w = 5'd9;
         2'd2: w = 5'd3;
         2'd3: w = 5'd1;
         default: w = 5'd1;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

FILE: src/bpt_encode.sv
// per byte encoding: data character, plane weighting and group tag state
// depends on bpt_pkg
`default_nettype none

module bpt_encode (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 fire,
   input  wire logic [7:0]           byte_value,
   input  wire logic                 end_of_message,
   output bpt_pkg::enc_out_type      enc_out
);
   import bpt_pkg::*;

   logic [1:0] pos_ff, pos_in;
   logic [6:0] acc_ff, acc_in;
   logic [7:0] term;
   logic [7:0] sum;
   logic [6:0] tag_idx;
   logic       close;

   assign term    = 8'(byte_plane(byte_value)) * 8'(pos_weight(pos_ff));
   assign sum     = {1'b0, acc_ff} + term;
   assign close   = end_of_message || (pos_ff == 2'd3);
   assign tag_idx = (sum >= 8'(TAG_ENTRIES)) ? TAG_LAST : sum[6:0];

   always_comb begin
      enc_out.data.kind = KIND_DATA;
      enc_out.data.code = data_char(byte_value);
      enc_out.data.last = !close;
      enc_out.tag.kind  = KIND_TAG;
      enc_out.tag.code  = tag_char(tag_idx);
      enc_out.tag.last  = 1'b1;
      enc_out.close     = close;
   end

   always_comb begin
      pos_in = pos_ff;
      acc_in = acc_ff;
      if (fire) begin
         if (close) begin
            pos_in = 2'd0;
            acc_in = 7'd0;
         end else begin
            pos_in = pos_ff + 2'd1;
            acc_in = sum[6:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 2'd0;
         acc_ff <= 7'd0;
      end else begin
         pos_ff <= pos_in;
         acc_ff <= acc_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/bpt_result_fifo.sv
// result queue: takes one or two entries per cycle, hands out one
// depends on bpt_pkg
`default_nettype none

module bpt_result_fifo #(
   parameter int Depth = bpt_pkg::FIFO_DEPTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push_first,
   input  wire logic                   push_second,
   input  wire bpt_pkg::rsp_entry_type first_entry,
   input  wire bpt_pkg::rsp_entry_type second_entry,
   input  wire logic                   pop,
   output bpt_pkg::rsp_entry_type      head,
   output logic                        not_empty,
   output logic                        room_for_two,
   output logic [$clog2(Depth+1)-1:0]  count
);
   import bpt_pkg::*;

   localparam int AddrW  = $clog2(Depth);
   localparam int CountW = $clog2(Depth + 1);
   localparam logic [AddrW-1:0]  LastAddr = AddrW'(Depth - 1);

   rsp_entry_type     entry_ff [Depth];
   logic [AddrW-1:0]  wr_ff, wr_in, rd_ff, rd_in, wr_next;
   logic [CountW-1:0] count_ff, count_in;

   function automatic logic [AddrW-1:0] inc(input logic [AddrW-1:0] a);
      return (a == LastAddr) ? '0 : a + AddrW'(1);
   endfunction

   assign wr_next      = inc(wr_ff);
   assign head         = entry_ff[rd_ff];
   assign not_empty    = (count_ff != '0);
   assign room_for_two = (count_ff <= CountW'(Depth - 2));
   assign count        = count_ff;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push_first) begin
         wr_in = push_second ? inc(wr_next) : wr_next;
      end
      if (pop) begin
         rd_in = inc(rd_ff);
      end
      count_in = count_ff + CountW'(push_first) + CountW'(push_first && push_second)
               - CountW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_first) begin
         entry_ff[wr_ff] <= first_entry;
         if (push_second) begin
            entry_ff[wr_next] <= second_entry;
         end
      end
   end

endmodule

`default_nettype wire

FILE: src/byte_plane_tag_text_encoder.sv
// path: a taken byte waits in the input register, then its results enter the result queue
// throughput: one byte per cycle while the small result queue has room for two; a closing
//   byte yields two results, drained one per cycle; closing runs settle at the output rate
// reset: synchronous, active high; clears input valid, group position, tag sum, queue
// depends on bpt_pkg, bpt_encode, bpt_result_fifo and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module byte_plane_tag_text_encoder #(
   parameter int FifoDepth = bpt_pkg::FIFO_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] byte_value
   input  wire logic       req_tlast,   // end_of_message
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] code
   output logic            rsp_tuser,   // kind
   output logic            rsp_tlast    // last_of_run
);
   import bpt_pkg::*;

   localparam int CountW = $clog2(FifoDepth + 1);

   logic              in_valid_ff, in_valid_in;
   logic [7:0]        in_byte_ff;
   logic              in_last_ff;
   logic              advance;
   logic              room_for_two;
   logic              not_empty;
   logic              pop;
   logic [CountW-1:0] count;
   enc_out_type       enc_out;
   rsp_entry_type     head;

   assign advance     = in_valid_ff && room_for_two;
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   bpt_encode u_encode (
      .clock          (clock),
      .reset          (reset),
      .fire           (advance),
      .byte_value     (in_byte_ff),
      .end_of_message (in_last_ff),
      .enc_out        (enc_out)
   );

   assign pop = not_empty && rsp_tready;

   bpt_result_fifo #(
      .Depth (FifoDepth)
   ) u_fifo (
      .clock        (clock),
      .reset        (reset),
      .push_first   (advance),
      .push_second  (enc_out.close),
      .first_entry  (enc_out.data),
      .second_entry (enc_out.tag),
      .pop          (pop),
      .head         (head),
      .not_empty    (not_empty),
      .room_for_two (room_for_two),
      .count        (count)
   );

   assign rsp_tvalid = not_empty;
   assign rsp_tdata  = head.code;
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last;

   // queue never overfills
   `ASSERT_SAME(a_fifo_bound, clock, reset, 1'b1, count <= CountW'(FifoDepth))
   // a tag character always closes the run of its byte
   `ASSERT_SAME(a_tag_last, clock, reset, rsp_tvalid && rsp_tuser == KIND_TAG, rsp_tlast)
   // a held byte that cannot move on stays held
   `ASSERT_NEXT(a_hold, clock, reset, in_valid_ff && !advance, in_valid_ff)

endmodule

`default_nettype wire

FILE: dv/byte_plane_tag_text_encoder_test.sv
// self-checking testbench for byte_plane_tag_text_encoder: directed rows, then random messages
// predicts data and tag characters per byte and checks every result transaction in order
// depends on bpt_pkg and the encoder rtl
`timescale 1ns / 1ps

module byte_plane_tag_text_encoder_test;

   import bpt_pkg::*;

   localparam int RANDOM_ITEMS   = 1800;
   localparam int HOLD_AT        = 600;
   localparam int HOLD_CYCLES    = 300;
   localparam int CALM_AT        = 1500;
   localparam int DIRECTED_ROWS  = 22;
   localparam int DRAIN_CYCLES   = 12;
   localparam int CYCLE_LIMIT    = 400000;

   typedef struct {
      logic [7:0] value;
      logic       last;
      bit         fixed;
      logic [7:0] data_code;
      logic [7:0] tag_code;
   } stim_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = '0;
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tuser;
   logic       rsp_tlast;

   // expectation typed into the current row travels beside the transaction
   bit         row_fixed = 1'b0;
   logic [7:0] row_data_code = '0;
   logic [7:0] row_tag_code = '0;

   bit hold_request = 1'b0;
   bit hold_done = 1'b0;
   bit calm = 1'b0;
   int mismatches = 0;
   int cycle_count = 0;

   logic [1:0] group_pos = '0;
   logic [6:0] group_sum = '0;
   rsp_entry_type pending_chars [$];

   string data_text = {
      "@ABCDEFGHIJKLMNOPQRSTUVWXYZ[2]^/",
      "_!*#$%$'()*+,-./0123456789:;(=)?",
      "@ABCDEFGHIJKLMNOPQRSTUVWXYZ[!]^_",
      "`abcdefghijklmnopqrstuvwxyz{|}~?",
      "`abcdefghijklmnopqrstuvwxyz{|}~.",
      "_!0#$%#'()*+,-./0123456789:;1=3?",
      "@ABCDEFGHIJKLMNOPQRSTUVWXYZ[4]^7",
      "`abcdefghijklmnopqrstuvwxyz{|}~="};

   string plane_text = {
      "11111111111111111111111111111111",
      "00100010000000000000000000001010",
      "00000000000000000000000000001001",
      "00000000000000000000000000000001",
      "11111111111111111111111111111111",
      "22122212222222222222222222221212",
      "22222222222222222222222222221221",
      "22222222222222222222222222222221"};

   string tag_text = {
      "`.^,JK|ST", "~@ELMNUVW", ":GHOPQXYZ",
      "'abijkrst", "cdelmnuvw", "fghopqxyz",
      ";129[]FI(", "345{}A)=#", "678BCD*$%"};

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      // lone bytes from a fresh group: data char plus the tag of one plane
      '{8'h00, 1'b1, 1'b1, "@", "'"},
      '{8'hFF, 1'b1, 1'b1, "=", "'"},
      '{8'h41, 1'b1, 1'b1, "A", 8'h60},
      '{8'hC1, 1'b1, 1'b1, "A", ";"},
      // full groups, the second one reaching the top tag index
      '{8'hFF, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'hFF, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'hFF, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'hFF, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'hC1, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'hC1, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'hC1, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'hC1, 1'b0, 1'b0, 8'h00, 8'h00},
      // end flag on the fourth byte closes only once
      '{8'h20, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'h20, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'h20, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'h22, 1'b1, 1'b0, 8'h00, 8'h00},
      // short final groups
      '{8'h80, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'h41, 1'b1, 1'b0, 8'h00, 8'h00},
      '{8'h7F, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'h22, 1'b0, 1'b0, 8'h00, 8'h00},
      '{8'h3C, 1'b1, 1'b0, 8'h00, 8'h00},
      '{8'h5C, 1'b1, 1'b1, "!", "'"}
   };

   byte_plane_tag_text_encoder i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [7:0] byte_value
      .req_tlast  (req_tlast),    // end_of_message
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [7:0] code
      .rsp_tuser  (rsp_tuser),    // kind
      .rsp_tlast  (rsp_tlast)     // last_of_run
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [6:0] group_weight(input logic [1:0] pos);
      case (pos)
         2'd0: return 7'd27;
         2'd1: return 7'd9;
         2'd2: return 7'd3;
         default: return 7'd1;
      endcase
   endfunction

   // character results for one accepted byte, data first, tag when the group closes
   task automatic encode_byte(input logic [7:0] value, input logic last, input bit fixed,
                              input logic [7:0] fixed_data, input logic [7:0] fixed_tag);
      rsp_entry_type entry;
      logic [1:0] plane;
      logic [7:0] sum;
      bit closes;
      plane = 2'(plane_text[value] - "0");
      sum = 8'(group_sum) + 8'(plane) * 8'(group_weight(group_pos));
      closes = last || group_pos == 2'd3;
      entry.kind = KIND_DATA;
      entry.code = fixed ? fixed_data : 8'(data_text[value]);
      entry.last = !closes;
      pending_chars.push_back(entry);
      if (closes) begin
         if (sum > 8'd80) begin
            sum = 8'd80;
         end
         entry.kind = KIND_TAG;
         entry.code = fixed ? fixed_tag : 8'(tag_text[sum]);
         entry.last = 1'b1;
         pending_chars.push_back(entry);
         group_pos = '0;
         group_sum = '0;
      end else begin
         group_pos = group_pos + 2'd1;
         group_sum = sum[6:0];
      end
   endtask

   task automatic check_char;
      rsp_entry_type want;
      if (pending_chars.size() == 0) begin
         $error("result transaction with nothing expected: kind %0d code %h", rsp_tuser,
                rsp_tdata);
         mismatches++;
      end else begin
         want = pending_chars.pop_front();
         if (rsp_tuser !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, rsp_tuser);
            mismatches++;
         end
         if (rsp_tdata !== want.code) begin
            $error("code: expected %h, got %h", want.code, rsp_tdata);
            mismatches++;
         end
         if (rsp_tlast !== want.last) begin
            $error("last_of_run: expected %0d, got %0d", want.last, rsp_tlast);
            mismatches++;
         end
      end
   endtask

   // input side predicted before output side so a same-edge result never races
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         encode_byte(req_tdata, req_tlast, row_fixed, row_data_code, row_tag_code);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         check_char();
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // called at a rising edge; returns at the edge where the transaction is taken
   task automatic send_byte(input logic [7:0] value, input logic last, input bit fixed,
                            input logic [7:0] data_code, input logic [7:0] tag_code);
      req_tvalid <= 1'b1;
      req_tdata <= value;
      req_tlast <= last;
      row_fixed <= fixed;
      row_data_code <= data_code;
      row_tag_code <= tag_code;
      do @(posedge clock); while (!req_tready);
   endtask

   // receiver: random stall bursts, calm stretches, and one long hold-off
   initial begin
      int phase_left;
      bit stalling;
      phase_left = 0;
      stalling = 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(20, 120);
            stalling = $urandom_range(0, 2) != 0;
         end
         if (hold_request && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else if (stalling && !calm && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
         phase_left--;
      end
   end

   initial begin
      int sent;
      int msg_len;
      bit gappy;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if ($urandom_range(0, 2) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
         send_byte(directed_rows[i].value, directed_rows[i].last, directed_rows[i].fixed,
                   directed_rows[i].data_code, directed_rows[i].tag_code);
      end

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 9);
         gappy = $urandom_range(0, 2) != 0;
         for (int k = 0; k < msg_len && sent < RANDOM_ITEMS; k++) begin
            if (sent == HOLD_AT) begin
               hold_request = 1'b1;
            end
            calm = sent >= CALM_AT;
            // keep offering during the hold-off so the block backs up into its input
            if (gappy && !calm && !(hold_request && !hold_done)
                && $urandom_range(0, 3) == 0) begin
               req_tvalid <= 1'b0;
               repeat ($urandom_range(1, 11)) @(posedge clock);
            end
            send_byte(8'($urandom_range(0, 255)),
                      (k == msg_len - 1) || (sent == RANDOM_ITEMS - 1), 1'b0, 8'h00, 8'h00);
            sent++;
         end
      end
      req_tvalid <= 1'b0;

      while (pending_chars.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
